// File: hw/rtl/wpe_pkg.sv
// Shared types, constants and the arctangent table of the wall line estimator.
package wpe_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned ZBits       = 34;   // angle accumulator, 2^-32 turn units
  localparam int unsigned AtanEntries = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MIN_VALID   = 3'd0,
    REG_RELIABLE    = 3'd1,
    REG_MAX_DIFF    = 3'd2,
    REG_SINE_SIDE   = 3'd3,
    REG_COSINE_SIDE = 3'd4,
    REG_SINE_FRONT  = 3'd5,
    REG_COSINE_FRONT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic        [15:0] min_dist;
    logic        [15:0] max_dist;
    logic        [15:0] max_diff;
    logic signed [15:0] sine_side;
    logic signed [15:0] cosine_side;
    logic signed [15:0] sine_front;
    logic signed [15:0] cosine_front;
  } wpe_cfg_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/wpe_if.sv
// Valid/ready channel interfaces for reading sets and wall estimates.
interface wpe_in_if #(
  parameter int unsigned DISTANCE_BITS = 13
);
  logic                     valid;
  logic                     ready;
  logic [DISTANCE_BITS-1:0] left_far_distance;
  logic [DISTANCE_BITS-1:0] left_near_distance;
  logic [DISTANCE_BITS-1:0] right_far_distance;
  logic [DISTANCE_BITS-1:0] right_near_distance;

  modport source (output valid, left_far_distance, left_near_distance,
                  right_far_distance, right_near_distance, input ready);
  modport sink (input valid, left_far_distance, left_near_distance,
                right_far_distance, right_near_distance, output ready);
endinterface

interface wpe_out_if #(
  parameter int unsigned DISTANCE_BITS = 13
);
  logic                     valid;
  logic                     ready;
  logic                     left_ok;
  logic [DISTANCE_BITS:0]   left_distance_half;
  logic signed [15:0]       left_tilt;
  logic                     right_ok;
  logic [DISTANCE_BITS:0]   right_distance_half;
  logic signed [15:0]       right_tilt;

  modport source (output valid, left_ok, left_distance_half, left_tilt,
                  right_ok, right_distance_half, right_tilt, input ready);
  modport sink (input valid, left_ok, left_distance_half, left_tilt,
                right_ok, right_distance_half, right_tilt, output ready);
endinterface

// File: hw/rtl/wpe_front.sv
// Front end: accept reading sets, check windows, form wall vectors per pair.
module wpe_front
  import wpe_pkg::*;
#(
  parameter int unsigned DISTANCE_BITS = 13,
  parameter int unsigned ENTRY_BITS    = 3 * DISTANCE_BITS + 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpe_cfg_t             cfg_i,
  wpe_in_if.sink               in_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output logic [ENTRY_BITS-1:0] entry_o [2]
);
  localparam int unsigned D  = DISTANCE_BITS;
  localparam int unsigned PW = D + 17;
  localparam int unsigned VW = D + 19;

  logic va_q, vb_q, ready_a, ready_b;
  logic [D-1:0]          far_q [2], near_q [2];
  logic                  ok_q [2];
  logic signed [PW-1:0]  psf_q [2], psn_q [2], pcf_q [2], pcn_q [2];
  logic [ENTRY_BITS-1:0] entry_q [2];

  logic [D-1:0]          far_w [2], near_w [2];
  logic                  ok_w [2];
  logic [ENTRY_BITS-1:0] entry_d [2];

  assign ready_b      = !vb_q || push_ready_i;
  assign ready_a      = !va_q || ready_b;
  assign in_i.ready   = ready_a;
  assign push_valid_o = vb_q;
  assign entry_o      = entry_q;

  assign far_w[0]  = in_i.left_far_distance;
  assign near_w[0] = in_i.left_near_distance;
  assign far_w[1]  = in_i.right_far_distance;
  assign near_w[1] = in_i.right_near_distance;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [D-1:0] diff;
      logic         in_win;
      diff   = (far_w[l] >= near_w[l]) ? far_w[l] - near_w[l] : near_w[l] - far_w[l];
      in_win = (16'(far_w[l]) >= cfg_i.min_dist) && (16'(far_w[l]) <= cfg_i.max_dist) &&
               (16'(near_w[l]) >= cfg_i.min_dist) && (16'(near_w[l]) <= cfg_i.max_dist);
      ok_w[l] = in_win && (16'(diff) <= cfg_i.max_diff);
    end
  end

  // Stage A: checks and the four products per pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_a) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_i.valid) begin
      for (int l = 0; l < 2; l++) begin
        far_q[l]  <= far_w[l];
        near_q[l] <= near_w[l];
        ok_q[l]   <= ok_w[l];
        psf_q[l]  <= $signed({1'b0, far_w[l]}) * cfg_i.sine_side;
        psn_q[l]  <= $signed({1'b0, near_w[l]}) * cfg_i.sine_front;
        pcf_q[l]  <= $signed({1'b0, far_w[l]}) * cfg_i.cosine_side;
        pcn_q[l]  <= $signed({1'b0, near_w[l]}) * cfg_i.cosine_front;
      end
    end
  end

  // Stage B: vector differences; left pair mirrors by negating dx
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [VW-1:0] dxr, dx, dy;
      logic [D:0]           range_sum;
      dxr  = VW'(psf_q[l]) - VW'(psn_q[l]);
      dx   = (l == 0) ? -dxr : dxr;
      dy   = VW'(pcf_q[l]) - VW'(pcn_q[l]);
      range_sum = ok_q[l] ? ({1'b0, far_q[l]} + {1'b0, near_q[l]}) : '0;
      entry_d[l] = {ok_q[l], range_sum, dx, dy};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      entry_q <= entry_d;
    end
  end

endmodule

// File: hw/rtl/wpe_queue.sv
// Short register queue between front and back ends.
module wpe_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i [2],
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o [2]
);
  localparam int unsigned PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH][2];
  logic [PB-1:0]    wr_q, rd_q;
  logic [CB-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CB'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PB'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PB'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CB'(push) - CB'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/wpe_back.sv
// Back end: pipelined CORDIC arctangent for both pairs and output register.
module wpe_back
  import wpe_pkg::*;
#(
  parameter int unsigned DISTANCE_BITS       = 13,
  parameter int unsigned ARCTAN_STAGES       = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 7,
  parameter int unsigned ENTRY_BITS          = 3 * DISTANCE_BITS + 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic [ENTRY_BITS-1:0] entry_i [2],
  wpe_out_if.source             out_o
);
  localparam int unsigned D  = DISTANCE_BITS;
  localparam int unsigned VW = D + 19;
  localparam int unsigned W  = D + 21;
  localparam int unsigned N  = (ARCTAN_STAGES > AtanEntries) ? AtanEntries : ARCTAN_STAGES;
  localparam int unsigned F  = ANGLE_FRACTION_BITS;

  logic                    v_q   [N+1];
  logic                    ok_q  [N+1][2];
  logic                    flat_q[N+1][2];
  logic [D:0]              dist_q[N+1][2];
  logic signed [W-1:0]     x_q   [N+1][2];
  logic signed [W-1:0]     y_q   [N+1][2];
  logic signed [ZBits-1:0] z_q   [N+1][2];
  logic                    rdy   [N+2];

  logic                    vp_q;
  logic                    okp_q [2];
  logic [D:0]              distp_q [2];
  logic signed [15:0]      angp_q [2];

  assign rdy[N+1] = !vp_q || out_o.ready;
  for (genvar k = 0; k <= N; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign pop_ready_o = rdy[0];

  // Stage 0: fold backward vectors into the right half plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && pop_valid_i) begin
      for (int l = 0; l < 2; l++) begin
        logic signed [VW-1:0] dx, dy;
        logic signed [W-1:0]  dxe, dye;
        logic                 ok_e;
        logic [D:0]           sum_e;
        {ok_e, sum_e, dx, dy} = entry_i[l];
        dxe = W'(dx);
        dye = W'(dy);
        ok_q[0][l]   <= ok_e;
        dist_q[0][l] <= sum_e;
        flat_q[0][l] <= (dy == '0);
        if (dy[VW-1]) begin
          x_q[0][l] <= -dye;
          y_q[0][l] <= -dxe;
          z_q[0][l] <= dx[VW-1] ? -34'sd2147483648 : 34'sd2147483648;
        end else begin
          x_q[0][l] <= dye;
          y_q[0][l] <= dxe;
          z_q[0][l] <= '0;
        end
      end
    end
  end

  // One rotation per stage; stage k shifts by k - 1
  for (genvar k = 1; k <= N; k++) begin : g_iter
    localparam logic [4:0] S = 5'(k - 1);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_q[k-1]) begin
        for (int l = 0; l < 2; l++) begin
          logic signed [W-1:0]     xs, ys;
          logic signed [ZBits-1:0] a;
          xs = x_q[k-1][l] >>> S;
          ys = y_q[k-1][l] >>> S;
          a  = $signed({2'b00, atan_turn(S)});
          ok_q[k][l]   <= ok_q[k-1][l];
          flat_q[k][l] <= flat_q[k-1][l];
          dist_q[k][l] <= dist_q[k-1][l];
          if (!y_q[k-1][l][W-1]) begin
            x_q[k][l] <= x_q[k-1][l] + ys;
            y_q[k][l] <= y_q[k-1][l] - xs;
            z_q[k][l] <= z_q[k-1][l] + a;
          end else begin
            x_q[k][l] <= x_q[k-1][l] - ys;
            y_q[k][l] <= y_q[k-1][l] + xs;
            z_q[k][l] <= z_q[k-1][l] - a;
          end
        end
      end
    end
  end

  // Output: clamp, scale to 1/2^F degree, round half up, zero reject/flat angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (rdy[N+1]) begin
      vp_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N+1] && v_q[N]) begin
      for (int l = 0; l < 2; l++) begin
        logic signed [ZBits-1:0] zc;
        logic signed [41:0]      zm, rnd, sh;
        zc = z_q[N][l];
        if (zc > 34'sd2147483648)  zc = 34'sd2147483648;
        if (zc < -34'sd2147483648) zc = -34'sd2147483648;
        zm  = 42'(zc) * 42'sd360;
        rnd = zm + (42'sd1 <<< (31 - F));
        sh  = rnd >>> (32 - F);
        okp_q[l]   <= ok_q[N][l];
        distp_q[l] <= dist_q[N][l];
        angp_q[l]  <= (ok_q[N][l] && !flat_q[N][l]) ? 16'(sh) : '0;
      end
    end
  end

  assign out_o.valid               = vp_q;
  assign out_o.left_ok             = okp_q[0];
  assign out_o.left_distance_half  = distp_q[0];
  assign out_o.left_tilt           = angp_q[0];
  assign out_o.right_ok            = okp_q[1];
  assign out_o.right_distance_half = distp_q[1];
  assign out_o.right_tilt          = angp_q[1];

endmodule

// File: hw/rtl/two_pair_wall_line_estimator.sv
// Top level of the two-pair wall line estimator.
//
// Usage: in_i carries one beat per reading set (far and near range for the
// left and right pair). out_o returns one beat per set with, per pair, a
// valid flag, the summed range (half millimetres) and the wall angle in
// 1/2^ANGLE_FRACTION_BITS degree. A pair that fails the window or the
// difference check comes back with all fields zero.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle; unknown indexes are dropped.
// Pipeline: front stages (products, differences), the queue, then back
// stages (fold, one CORDIC rotation per stage, scale).
// Throughput: one reading set per cycle while out_o.ready is high; the
// pipelined CORDIC sets it.
// Stall: when out_o.ready is low the back pipeline holds and fills; the
// queue of QUEUE_DEPTH entries absorbs the front, and in_i.ready drops only
// once queue and front stages are full.
// Reset: all valid flags and queue pointers clear; config regs reset.
module two_pair_wall_line_estimator
  import wpe_pkg::*;
#(
  parameter int unsigned DISTANCE_BITS       = 13,
  parameter int unsigned ARCTAN_STAGES       = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 7,
  parameter int unsigned QUEUE_DEPTH         = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  wpe_in_if.sink                 in_i,
  wpe_out_if.source              out_o
);
  localparam int unsigned E = 3 * DISTANCE_BITS + 40;

  wpe_cfg_t cfg_q;
  logic [15:0] dmask;

  // Distance registers keep only DISTANCE_BITS bits
  assign dmask = 16'((17'd1 << DISTANCE_BITS) - 17'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist     <= 16'd30;
      cfg_q.max_dist     <= 16'd1200;
      cfg_q.max_diff     <= 16'd500;
      cfg_q.sine_side    <= 16'sd30792;
      cfg_q.cosine_side  <= 16'sd11207;
      cfg_q.sine_front   <= 16'sd11207;
      cfg_q.cosine_front <= 16'sd30792;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_VALID:    cfg_q.min_dist     <= cfg_data_i & dmask;
        REG_RELIABLE:     cfg_q.max_dist     <= cfg_data_i & dmask;
        REG_MAX_DIFF:     cfg_q.max_diff     <= cfg_data_i & dmask;
        REG_SINE_SIDE:    cfg_q.sine_side    <= $signed(cfg_data_i);
        REG_COSINE_SIDE:  cfg_q.cosine_side  <= $signed(cfg_data_i);
        REG_SINE_FRONT:   cfg_q.sine_front   <= $signed(cfg_data_i);
        REG_COSINE_FRONT: cfg_q.cosine_front <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic         f_valid, f_ready, b_valid, b_ready;
  logic [E-1:0] f_entry [2];
  logic [E-1:0] b_entry [2];

  wpe_front #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .ENTRY_BITS    (E)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .entry_o      (f_entry)
  );

  wpe_queue #(
    .WIDTH (E),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_entry),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_entry)
  );

  wpe_back #(
    .DISTANCE_BITS       (DISTANCE_BITS),
    .ARCTAN_STAGES       (ARCTAN_STAGES),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .ENTRY_BITS          (E)
  ) u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .entry_i     (b_entry),
    .out_o       (out_o)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for the two-pair wall line estimator.
module tb;
  import wpe_pkg::*;

  localparam int unsigned DistBits   = 13;
  localparam int unsigned Stages     = 16;
  localparam int unsigned FracBits   = 7;
  localparam int unsigned Latency    = 21;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [DistBits-1:0] left_far;
    logic [DistBits-1:0] left_near;
    logic [DistBits-1:0] right_far;
    logic [DistBits-1:0] right_near;
  } readings_t;

  typedef struct packed {
    logic               left_ok;
    logic [DistBits:0]  left_half;
    logic signed [15:0] left_tilt;
    logic               right_ok;
    logic [DistBits:0]  right_half;
    logic signed [15:0] right_tilt;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  wpe_in_if #(.DISTANCE_BITS(DistBits)) reading_ch ();
  wpe_out_if #(.DISTANCE_BITS(DistBits)) estimate_ch ();

  two_pair_wall_line_estimator #(
    .DISTANCE_BITS(DistBits),
    .ARCTAN_STAGES(Stages),
    .ANGLE_FRACTION_BITS(FracBits)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (reading_ch.sink),
    .out_o (estimate_ch.source)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Wall estimate predictor: holds its own copy of the register file.
  class wall_scoreboard;
    logic [DistBits-1:0] min_dist, max_dist, max_diff;
    longint sin_side, cos_side, sin_front, cos_front;
    estimate_t pending[$];

    function void reset_regs();
      min_dist = 30; max_dist = 1200; max_diff = 500;
      sin_side = 30792; cos_side = 11207; sin_front = 11207; cos_front = 30792;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        REG_MIN_VALID:    min_dist = val[DistBits-1:0];
        REG_RELIABLE:     max_dist = val[DistBits-1:0];
        REG_MAX_DIFF:     max_diff = val[DistBits-1:0];
        REG_SINE_SIDE:    sin_side = longint'($signed(val));
        REG_COSINE_SIDE:  cos_side = longint'($signed(val));
        REG_SINE_FRONT:   sin_front = longint'($signed(val));
        REG_COSINE_FRONT: cos_front = longint'($signed(val));
        default: ;
      endcase
    endfunction

    // CORDIC vectoring in 2^-32 turn units, floor shifts (>>> on signed).
    function longint wall_angle(longint dx, longint dy);
      longint x, y, z, xs, ys, t, q;
      longint turns[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      if (dy == 0) return 0;
      if (dy < 0) begin
        z = (dx >= 0) ? 64'sd2147483648 : -64'sd2147483648;
        x = -dy; y = -dx;
      end else begin
        z = 0; x = dy; y = dx;
      end
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += turns[i];
        end else begin
          x -= ys; y += xs; z -= turns[i];
        end
      end
      if (z > 64'sd2147483648) z = 64'sd2147483648;
      if (z < -64'sd2147483648) z = -64'sd2147483648;
      t = z * 360 * (64'sd1 <<< FracBits) + 64'sd2147483648;
      q = t >>> 32;
      return q;
    endfunction

    function void pair_estimate(longint far_d, longint near_d, longint sf, longint sn,
                                output logic ok, output logic [DistBits:0] half,
                                output logic signed [15:0] ang);
      longint dx, dy, a, diff;
      ok = 1'b0; half = '0; ang = '0;
      if (far_d < min_dist || far_d > max_dist || near_d < min_dist || near_d > max_dist)
        return;
      diff = (far_d >= near_d) ? far_d - near_d : near_d - far_d;
      if (diff > max_diff) return;
      dx = far_d * sf - near_d * sn;
      dy = far_d * cos_side - near_d * cos_front;
      a = wall_angle(dx, dy);
      ok = 1'b1;
      half = (DistBits + 1)'(far_d + near_d);
      ang = a[15:0];
    endfunction

    function void note_readings(readings_t r);
      estimate_t e;
      pair_estimate(r.left_far, r.left_near, -sin_side, -sin_front,
                    e.left_ok, e.left_half, e.left_tilt);
      pair_estimate(r.right_far, r.right_near, sin_side, sin_front,
                    e.right_ok, e.right_half, e.right_tilt);
      pending.push_back(e);
    endfunction

    task check_estimate(estimate_t got);
      estimate_t exp;
      if (pending.size() == 0) begin
        report_mismatch("estimate beat with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.left_ok !== exp.left_ok)
        report_mismatch($sformatf("left_ok %0d exp %0d", got.left_ok, exp.left_ok));
      if (got.left_half !== exp.left_half)
        report_mismatch($sformatf("left_half %0d exp %0d", got.left_half, exp.left_half));
      if (got.left_tilt !== exp.left_tilt)
        report_mismatch($sformatf("left_tilt %0d exp %0d", got.left_tilt, exp.left_tilt));
      if (got.right_ok !== exp.right_ok)
        report_mismatch($sformatf("right_ok %0d exp %0d", got.right_ok,
                                  exp.right_ok));
      if (got.right_half !== exp.right_half)
        report_mismatch($sformatf("right_half %0d exp %0d", got.right_half, exp.right_half));
      if (got.right_tilt !== exp.right_tilt)
        report_mismatch($sformatf("right_tilt %0d exp %0d", got.right_tilt,
                                  exp.right_tilt));
    endtask
  endclass

  wall_scoreboard board = new();

  initial begin
    reading_ch.valid = 1'b0;
    {reading_ch.left_far_distance, reading_ch.left_near_distance,
     reading_ch.right_far_distance, reading_ch.right_near_distance} = '0;
    estimate_ch.ready = 1'b0;
  end

  // Sample both channels at the rising edge; the predictor sees accepted beats only.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (reading_ch.valid && reading_ch.ready)
        board.note_readings({reading_ch.left_far_distance, reading_ch.left_near_distance,
                             reading_ch.right_far_distance, reading_ch.right_near_distance});
      if (estimate_ch.valid && estimate_ch.ready)
        board.check_estimate({estimate_ch.left_ok, estimate_ch.left_distance_half,
                              estimate_ch.left_tilt, estimate_ch.right_ok,
                              estimate_ch.right_distance_half, estimate_ch.right_tilt});
      if (cycle_count > CycleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver stalls at random; one assignment per falling edge.
  always @(negedge clk_i)
    estimate_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drive one beat, idle first at random (valid low), hold until accepted.
  task automatic send_readings(readings_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      reading_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    reading_ch.valid <= 1'b1;
    reading_ch.left_far_distance <= r.left_far;
    reading_ch.left_near_distance <= r.left_near;
    reading_ch.right_far_distance <= r.right_far;
    reading_ch.right_near_distance <= r.right_near;
    do @(posedge clk_i); while (!reading_ch.ready);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected estimate, then let the pipe settle.
  task automatic drain();
    reading_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  // Mostly readings near a shared distance so pairs pass the checks.
  function automatic logic [DistBits-1:0] near_reading(logic [DistBits-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(600)) - 300;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[DistBits-1:0];
  endfunction

  function automatic readings_t random_readings();
    readings_t r;
    logic [DistBits-1:0] bl, br;
    if ($urandom_range(9) < 2) begin
      r = (4 * DistBits)'({$urandom, $urandom});
    end else begin
      bl = DistBits'($urandom_range(8191)); br = DistBits'($urandom_range(8191));
      if ($urandom_range(1)) begin
        bl = DistBits'($urandom_range(1300)); br = DistBits'($urandom_range(1300));
      end
      r.left_far = bl; r.left_near = near_reading(bl);
      r.right_far = br; r.right_near = near_reading(br);
      if ($urandom_range(9) == 0) r.right_near = r.right_far;
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin send_idle_pct = 36; recv_idle_pct = 71; end
      else if (i == n / 3) begin send_idle_pct = 71; recv_idle_pct = 36; end
      else if (i == 2 * n / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      send_readings(random_readings());
    end
    send_idle_pct = 0;
    drain();
  endtask

  initial begin
    board.reset_regs();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: window edges, difference limit, backward vectors.
    send_idle_pct = 36; recv_idle_pct = 71;
    send_readings({13'd30, 13'd30, 13'd1200, 13'd1200});
    send_readings({13'd29, 13'd30, 13'd1201, 13'd1200});
    send_readings({13'd700, 13'd200, 13'd200, 13'd701});
    send_readings({13'd1000, 13'd500, 13'd500, 13'd1000});
    send_readings({13'd0, 13'd8191, 13'd8191, 13'd0});
    send_readings({13'd400, 13'd145, 13'd145, 13'd400});
    send_readings({13'd300, 13'd300, 13'd100, 13'd100});
    drain();
    // Equal cosines and sines; equal readings give a flat wall with dx zero.
    write_reg(REG_COSINE_FRONT, 16'd11207);
    write_reg(REG_SINE_FRONT, 16'd30792);
    send_readings({13'd500, 13'd500, 13'd800, 13'd800});
    send_readings({13'd500, 13'd600, 13'd600, 13'd500});
    drain();
    // Extreme registers: wide window, negative and extreme constants.
    write_reg(REG_MIN_VALID, 16'd0);
    write_reg(REG_RELIABLE, 16'hffff);
    write_reg(REG_MAX_DIFF, 16'd8191);
    write_reg(REG_SINE_SIDE, 16'h8000);
    write_reg(REG_COSINE_SIDE, 16'h7fff);
    write_reg(REG_SINE_FRONT, 16'h7fff);
    write_reg(REG_COSINE_FRONT, 16'h8000);
    write_reg(cfg_reg_e'(3'd7), 16'h1234);
    send_readings({13'd8191, 13'd0, 13'd0, 13'd8191});
    send_readings({13'd8191, 13'd8191, 13'd1, 13'd2});
    send_readings({13'd0, 13'd0, 13'h1555, 13'h0aaa});
    drain();
    random_phase(500);

    // Inverted window rejects everything; then random constants.
    write_reg(REG_MIN_VALID, 16'd5000);
    write_reg(REG_RELIABLE, 16'd100);
    random_phase(50);
    write_reg(REG_MIN_VALID, 16'($urandom_range(200)));
    write_reg(REG_RELIABLE, 16'd8191);
    write_reg(REG_MAX_DIFF, 16'($urandom_range(1000)));
    write_reg(REG_SINE_SIDE, 16'($urandom));
    write_reg(REG_COSINE_SIDE, 16'($urandom));
    write_reg(REG_SINE_FRONT, 16'($urandom));
    write_reg(REG_COSINE_FRONT, 16'($urandom));
    random_phase(450);

    // Back to reset-like geometry.
    write_reg(REG_MIN_VALID, 16'd30);
    write_reg(REG_RELIABLE, 16'd1200);
    write_reg(REG_MAX_DIFF, 16'd500);
    write_reg(REG_SINE_SIDE, 16'd30792);
    write_reg(REG_COSINE_SIDE, 16'd11207);
    write_reg(REG_SINE_FRONT, 16'd11207);
    write_reg(REG_COSINE_FRONT, 16'd30792);
    random_phase(500);

    if (error_count == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: two_pair_wall_line_estimator.f
hw/rtl/wpe_pkg.sv
hw/rtl/wpe_if.sv
hw/rtl/wpe_front.sv
hw/rtl/wpe_queue.sv
hw/rtl/wpe_back.sv
hw/rtl/two_pair_wall_line_estimator.sv
bench/tb.sv
